@@ rtl/apc_pkg.sv @@
// ============================================================================
// apc_pkg: shared definitions for the ASCII polar to Cartesian converter
// Field widths, character codes, fixed-point scaling, the quarter-wave sine
// table and the types passed between the parser, the pipeline and the axes.
// ============================================================================
package apc_pkg;

    // Fixed-point scaling of the sine table and of the output coordinates.
    localparam int SINE_FRAC_BITS  = 15;
    localparam int COORD_FRAC_BITS = 8;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int MAG_W      = 16;
    localparam int POINT_W    = 26;
    localparam int DIST_W     = 17;
    localparam int ANGLE_W    = 9;
    localparam int STATUS_W   = 2;

    // Output beat layout: x, y, distance and angle packed from bit 0 upward.
    localparam int PAYLOAD_W = 2 * POINT_W + DIST_W + ANGLE_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - PAYLOAD_W;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y    = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LIMIT = CFG_ADDR_W'(2);
    localparam logic signed [CFG_W-1:0] CENTER_X_RST  = CFG_W'(320);
    localparam logic signed [CFG_W-1:0] CENTER_Y_RST  = CFG_W'(240);
    localparam logic [CFG_W-1:0]        RANGE_LIM_RST = CFG_W'(450);

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Angle arithmetic. A 12-bit value below 3600 is divided by 360 through
    // the reciprocal 91 / 2^15, which never overestimates and is at most one low.
    localparam int ANGLE_MOD   = 360;
    localparam int QUARTER     = 90;
    localparam int RECIP_360   = 91;
    localparam int RECIP_SHIFT = 15;
    localparam int MAG_MAX     = (1 << MAG_W) - 1;

    // Sine table geometry.
    localparam int SINE_W     = SINE_FRAC_BITS + 1;
    localparam int ROM_DEPTH  = QUARTER + 1;
    localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);
    localparam longint unsigned PI_OVER_180_Q40 = 64'd19190098069;

    // Product rounding and coordinate sum widths.
    localparam int PROD_W     = MAG_W + SINE_W;
    localparam int SHR        = (SINE_FRAC_BITS > COORD_FRAC_BITS) ?
                                (SINE_FRAC_BITS - COORD_FRAC_BITS) : 0;
    localparam int SHL        = (SINE_FRAC_BITS > COORD_FRAC_BITS) ?
                                0 : (COORD_FRAC_BITS - SINE_FRAC_BITS);
    localparam int ROUND_BIAS = (1 << SHR) >> 1;
    localparam int TERM_W     = PROD_W + 1 + SHL;
    localparam int BASE_W     = CFG_W + COORD_FRAC_BITS;
    localparam int SUM_W      = ((TERM_W > BASE_W) ? TERM_W : BASE_W) + 2;
    localparam int PT_MAX     = (1 << (POINT_W - 1)) - 1;
    localparam int PT_MIN     = -(1 << (POINT_W - 1));

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_IN_RANGE     = 2'd0,
        ST_OUT_OF_RANGE = 2'd1,
        ST_MALFORMED    = 2'd2
    } status_t;

    // Position of the scanner within one number field.
    typedef enum logic [1:0] {
        SCAN_BEFORE = 2'd0,
        SCAN_SIGN   = 2'd1,
        SCAN_DIGITS = 2'd2,
        SCAN_DONE   = 2'd3
    } scan_t;

    // One finished line as handed from the parser to the pipeline.
    typedef struct packed {
        status_t                   status;
        logic [ANGLE_W-1:0]        angle;
        logic signed [DIST_W-1:0]  distance;
    } line_t;

    // Unsigned long division by shift and subtract; only used while the
    // table below is built at elaboration.
    function automatic logic [63:0] quot64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Builds the quarter-wave table at elaboration: a Q30 Taylor series of
    // sin(d degrees), rounded half up to SINE_FRAC_BITS fraction bits.
    function automatic logic [ROM_DEPTH*SINE_W-1:0] build_sine_rom();
        logic [ROM_DEPTH*SINE_W-1:0] rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] div;
        rom = '0;
        for (int d = 0; d < ROM_DEPTH; d++) begin
            x    = (64'(d) * PI_OVER_180_Q40 + 64'd512) >> 10;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
                div  = 64'((2 * n) * (2 * n + 1));
                term = quot64((term * x2) >> 30, div);
                if ((n & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sum = (sum + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
            rom[d*SINE_W +: SINE_W] = sum[SINE_W-1:0];
        end
        return rom;
    endfunction

    localparam logic [ROM_DEPTH*SINE_W-1:0] SINE_ROM = build_sine_rom();

    // Table read: sine magnitude of 0 to 90 degrees.
    function automatic logic [SINE_W-1:0] sine_at(input logic [ROM_IDX_W-1:0] idx);
        return SINE_ROM[32'(idx) * SINE_W +: SINE_W];
    endfunction

endpackage

@@ rtl/apc_parse.sv @@
// ============================================================================
// apc_parse: line scanner for "angle,distance" text
// Scans one character per accepted beat, folds the angle modulo 360 and
// saturates the distance, and hands a finished line on every newline.
// ============================================================================
module apc_parse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_beat,     // a character is taken this cycle
    input  logic                        adv,         // pipeline moves this cycle
    input  logic [apc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [apc_pkg::CFG_W-1:0]   range_limit,
    output logic                        line_vld,
    output apc_pkg::line_t              line
);
    import apc_pkg::*;

    logic              field_reg,      field_next;
    scan_t             scan_reg,       scan_next;
    logic [ANGLE_W-1:0] ang_res_reg,   ang_res_next;
    logic              ang_neg_reg,    ang_neg_next;
    logic              ang_seen_reg,   ang_seen_next;
    logic [MAG_W-1:0]  dist_mag_reg,   dist_mag_next;
    logic              dist_neg_reg,   dist_neg_next;
    logic              dist_seen_reg,  dist_seen_next;
    logic              bad_reg,        bad_next;
    logic              line_vld_reg;
    line_t             line_reg,       line_next;

    logic                 is_nl;
    logic                 is_comma;
    logic                 is_blank;
    logic                 is_sign;
    logic                 is_minus;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [11:0]          ang_acc;
    logic [18:0]          ang_q_prod;
    logic [3:0]           ang_q;
    logic [11:0]          ang_rem;
    logic [19:0]          dist_acc;
    logic                 malformed;
    logic                 beyond;

    // Character classes.
    assign is_nl    = (rx_byte == CH_NL);
    assign is_comma = (rx_byte == CH_COMMA);
    assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_CR) ||
                      (rx_byte == CH_VT) || (rx_byte == CH_FF);
    assign is_minus = (rx_byte == CH_MINUS);
    assign is_sign  = (rx_byte == CH_PLUS) || is_minus;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit    = 4'(rx_byte - CH_ZERO);

    // Angle digit step: (residue * 10 + digit) mod 360 by reciprocal and one correction.
    always_comb begin
        ang_acc    = 12'(ang_res_reg) * 12'd10 + 12'(digit);
        ang_q_prod = 19'(ang_acc) * 19'(RECIP_360);
        ang_q      = 4'(ang_q_prod >> RECIP_SHIFT);
        ang_rem    = ang_acc - 12'(ang_q) * 12'(ANGLE_MOD);
        if (ang_rem >= 12'(ANGLE_MOD)) begin
            ang_rem = ang_rem - 12'(ANGLE_MOD);
        end
    end

    // Distance digit step with saturation.
    assign dist_acc = 20'(dist_mag_reg) * 20'd10 + 20'(digit);

    // Next scan state.
    always_comb begin
        field_next     = field_reg;
        scan_next      = scan_reg;
        ang_res_next   = ang_res_reg;
        ang_neg_next   = ang_neg_reg;
        ang_seen_next  = ang_seen_reg;
        dist_mag_next  = dist_mag_reg;
        dist_neg_next  = dist_neg_reg;
        dist_seen_next = dist_seen_reg;
        bad_next       = bad_reg;
        if (in_beat) begin
            if (is_nl) begin
                field_next     = 1'b0;
                scan_next      = SCAN_BEFORE;
                ang_res_next   = '0;
                ang_neg_next   = 1'b0;
                ang_seen_next  = 1'b0;
                dist_mag_next  = '0;
                dist_neg_next  = 1'b0;
                dist_seen_next = 1'b0;
                bad_next       = 1'b0;
            end else if (!field_reg && is_comma) begin
                bad_next   = bad_reg || !ang_seen_reg;
                field_next = 1'b1;
                scan_next  = SCAN_BEFORE;
            end else if (scan_reg == SCAN_BEFORE && is_blank) begin
                // Leading blanks are skipped.
                scan_next = SCAN_BEFORE;
            end else if (scan_reg == SCAN_BEFORE && is_sign) begin
                if (!field_reg) begin
                    ang_neg_next = is_minus;
                end else begin
                    dist_neg_next = is_minus;
                end
                scan_next = SCAN_SIGN;
            end else if (scan_reg != SCAN_DONE && is_digit) begin
                if (!field_reg) begin
                    ang_res_next  = ANGLE_W'(ang_rem);
                    ang_seen_next = 1'b1;
                end else begin
                    dist_mag_next  = (dist_acc > 20'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                                                               : dist_acc[MAG_W-1:0];
                    dist_seen_next = 1'b1;
                end
                scan_next = SCAN_DIGITS;
            end else begin
                scan_next = SCAN_DONE;
            end
        end
    end

    // Finished line as it stands when the newline arrives.
    always_comb begin
        malformed = bad_reg || !ang_seen_reg || !field_reg || !dist_seen_reg;
        beyond    = (!dist_neg_reg || dist_mag_reg == '0) && (dist_mag_reg >= range_limit);
        line_next = '0;
        if (malformed) begin
            line_next.status = ST_MALFORMED;
        end else begin
            line_next.status   = beyond ? ST_OUT_OF_RANGE : ST_IN_RANGE;
            line_next.angle    = (ang_neg_reg && ang_res_reg != '0) ?
                                 (ANGLE_W'(ANGLE_MOD) - ang_res_reg) : ang_res_reg;
            line_next.distance = dist_neg_reg ? -$signed({1'b0, dist_mag_reg})
                                              : $signed({1'b0, dist_mag_reg});
        end
    end

    // Scan state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg     <= 1'b0;
            scan_reg      <= SCAN_BEFORE;
            ang_res_reg   <= '0;
            ang_neg_reg   <= 1'b0;
            ang_seen_reg  <= 1'b0;
            dist_mag_reg  <= '0;
            dist_neg_reg  <= 1'b0;
            dist_seen_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end else begin
            field_reg     <= field_next;
            scan_reg      <= scan_next;
            ang_res_reg   <= ang_res_next;
            ang_neg_reg   <= ang_neg_next;
            ang_seen_reg  <= ang_seen_next;
            dist_mag_reg  <= dist_mag_next;
            dist_neg_reg  <= dist_neg_next;
            dist_seen_reg <= dist_seen_next;
            bad_reg       <= bad_next;
        end
    end

    // Line hand-off register, first pipeline stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_vld_reg <= 1'b0;
        end else if (adv) begin
            line_vld_reg <= in_beat && is_nl;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            line_reg <= line_next;
        end
    end

    assign line_vld = line_vld_reg;
    assign line     = line_reg;

endmodule

@@ rtl/apc_axis.sv @@
// ============================================================================
// apc_axis: one coordinate axis
// Multiplies distance by a trig magnitude with rounding, then applies the
// sign, adds the scaled center and saturates, one register after each step.
// ============================================================================
module apc_axis (
    input  logic                               aclk,
    input  logic                               adv,
    input  logic signed [apc_pkg::CFG_W-1:0]   center,
    input  logic [apc_pkg::MAG_W-1:0]          dist_mag,
    input  logic                               dist_neg,
    input  logic [apc_pkg::SINE_W-1:0]         trig_mag,
    input  logic                               trig_neg,
    input  logic                               kill,      // malformed line: force zero
    output logic signed [apc_pkg::POINT_W-1:0] coord
);
    import apc_pkg::*;

    logic [PROD_W-1:0]         prod;
    logic [PROD_W:0]           prod_rnd;
    logic [TERM_W-1:0]         term_reg,  term_next;
    logic                      neg_reg;
    logic signed [SUM_W-1:0]   base;
    logic signed [SUM_W-1:0]   term_s;
    logic signed [SUM_W-1:0]   sum;
    logic signed [POINT_W-1:0] coord_reg, coord_next;

    // Product magnitude, rounded half away from zero to the coordinate scale.
    always_comb begin
        prod      = PROD_W'(dist_mag) * PROD_W'(trig_mag);
        prod_rnd  = ((PROD_W + 1)'(prod) + (PROD_W + 1)'(ROUND_BIAS)) >> SHR;
        term_next = TERM_W'(prod_rnd) << SHL;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            term_reg <= term_next;
            neg_reg  <= dist_neg ^ trig_neg;
        end
    end

    // Signed sum with the center and saturation to the coordinate range.
    always_comb begin
        base   = SUM_W'(center) <<< COORD_FRAC_BITS;
        term_s = $signed(SUM_W'(term_reg));
        sum    = base + (neg_reg ? -term_s : term_s);
        if (kill) begin
            coord_next = '0;
        end else if (sum > SUM_W'(PT_MAX)) begin
            coord_next = POINT_W'(PT_MAX);
        end else if (sum < SUM_W'(PT_MIN)) begin
            coord_next = POINT_W'(PT_MIN);
        end else begin
            coord_next = POINT_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

@@ rtl/ascii_polar_to_cartesian_core.sv @@
// ============================================================================
// ascii_polar_to_cartesian_core: serial "angle,distance" text to x/y points
// Top level with configuration registers, line scanner, trig lookup and the
// two coordinate axes in a four-register pipeline.
// ============================================================================
// Usage:
//   The slave channel takes one ASCII character per beat in s_tdata. Lines
//   look like "angle,distance" followed by a newline. Every newline beat
//   yields exactly one master beat; other characters yield none.
//   The master beat carries x and y in signed pixels with COORD_FRAC_BITS
//   fraction bits, the parsed distance and angle in m_tdata, and the status
//   (in range, at or beyond the range limit, malformed) in m_tuser.
//   Pipeline: a taken newline beat moves through the scanner, trig table,
//   multiply and sum stages, the last of which is the output register.
//   Throughput: one character per cycle; the stages move together and are
//   only held while a finished result waits on m_tready.
//   Stall: with the output register full and m_tready low, s_tready drops
//   and every stage holds its contents.
//   Reset: the scanner starts a fresh line, the pipeline empties, and the
//   center is (320, 240), range limit 450. The user writes registers through
//   cfg_wr_en / cfg_addr / cfg_wdata only with no line in flight; unchecked.
// ============================================================================
module ascii_polar_to_cartesian_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input characters. s_tdata: rx_byte [7:0].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [apc_pkg::BYTE_W-1:0]      s_tdata,
    // Points. m_tdata: point_x [25:0], point_y [51:26], distance [68:52],
    // angle_deg [77:69], zero fill [79:78]. m_tuser: status [1:0].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [apc_pkg::TDATA_W-1:0]     m_tdata,
    output logic [apc_pkg::STATUS_W-1:0]    m_tuser,
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [apc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [apc_pkg::CFG_W-1:0]       cfg_wdata
);
    import apc_pkg::*;

    logic signed [CFG_W-1:0] center_x_reg;
    logic signed [CFG_W-1:0] center_y_reg;
    logic [CFG_W-1:0]        range_limit_reg;

    logic                    adv;
    logic                    in_beat;
    logic                    line_vld;
    line_t                   line;

    logic [1:0]              quad;
    logic [1:0]              quad_cos;
    logic [ROM_IDX_W-1:0]    rem;
    logic [SINE_W-1:0]       rom_lo;
    logic [SINE_W-1:0]       rom_hi;

    logic                    t_vld_reg;
    line_t                   t_line_reg;
    logic [SINE_W-1:0]       sin_mag_reg;
    logic                    sin_neg_reg;
    logic [SINE_W-1:0]       cos_mag_reg;
    logic                    cos_neg_reg;
    logic [MAG_W-1:0]        dmag_reg;
    logic                    dneg_reg;

    logic                    mul_vld_reg;
    line_t                   mul_line_reg;
    logic                    out_vld_reg;
    line_t                   out_line_reg;

    logic                    kill;
    logic signed [POINT_W-1:0] coord_x;
    logic signed [POINT_W-1:0] coord_y;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= CENTER_X_RST;
            center_y_reg    <= CENTER_Y_RST;
            range_limit_reg <= RANGE_LIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CENTER_X:    center_x_reg    <= $signed(cfg_wdata);
                REG_CENTER_Y:    center_y_reg    <= $signed(cfg_wdata);
                REG_RANGE_LIMIT: range_limit_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves whenever the output register can take a beat.
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign in_beat  = s_tvalid && adv;

    apc_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_beat     (in_beat),
        .adv         (adv),
        .rx_byte     (s_tdata),
        .range_limit (range_limit_reg),
        .line_vld    (line_vld),
        .line        (line)
    );

    // Quadrant split and table lookup; cosine is the sine one quadrant on.
    always_comb begin
        if (line.angle < ANGLE_W'(QUARTER)) begin
            quad = 2'd0;
            rem  = ROM_IDX_W'(line.angle);
        end else if (line.angle < ANGLE_W'(2 * QUARTER)) begin
            quad = 2'd1;
            rem  = ROM_IDX_W'(line.angle - ANGLE_W'(QUARTER));
        end else if (line.angle < ANGLE_W'(3 * QUARTER)) begin
            quad = 2'd2;
            rem  = ROM_IDX_W'(line.angle - ANGLE_W'(2 * QUARTER));
        end else begin
            quad = 2'd3;
            rem  = ROM_IDX_W'(line.angle - ANGLE_W'(3 * QUARTER));
        end
        quad_cos = quad + 2'd1;
        rom_lo   = sine_at(rem);
        rom_hi   = sine_at(ROM_IDX_W'(QUARTER) - rem);
    end

    // Trig stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_vld_reg <= 1'b0;
        end else if (adv) begin
            t_vld_reg <= line_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_line_reg  <= line;
            sin_mag_reg <= quad[0] ? rom_hi : rom_lo;
            sin_neg_reg <= quad[1];
            cos_mag_reg <= quad_cos[0] ? rom_hi : rom_lo;
            cos_neg_reg <= quad_cos[1];
            dmag_reg    <= line.distance[DIST_W-1] ? MAG_W'(-line.distance)
                                                   : MAG_W'(line.distance);
            dneg_reg    <= line.distance[DIST_W-1];
        end
    end

    // Multiply and output stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            mul_vld_reg <= t_vld_reg;
            out_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_line_reg <= t_line_reg;
            out_line_reg <= mul_line_reg;
        end
    end

    assign kill = (mul_line_reg.status == ST_MALFORMED);

    apc_axis u_axis_x (
        .aclk     (aclk),
        .adv      (adv),
        .center   (center_x_reg),
        .dist_mag (dmag_reg),
        .dist_neg (dneg_reg),
        .trig_mag (cos_mag_reg),
        .trig_neg (cos_neg_reg),
        .kill     (kill),
        .coord    (coord_x)
    );

    apc_axis u_axis_y (
        .aclk     (aclk),
        .adv      (adv),
        .center   (center_y_reg),
        .dist_mag (dmag_reg),
        .dist_neg (dneg_reg),
        .trig_mag (sin_mag_reg),
        .trig_neg (sin_neg_reg),
        .kill     (kill),
        .coord    (coord_y)
    );

    // Output beat.
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_line_reg.angle, out_line_reg.distance,
                       coord_y, coord_x};
    assign m_tuser  = out_line_reg.status;

`ifndef SYNTH
    // A newline beat always produces a finished line in the next cycle.
    a_newline_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata == CH_NL) |=> line_vld)
        else $error("newline beat did not produce a line");

    // Any other character beat produces no line.
    a_other_no_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata != CH_NL) |=> !line_vld)
        else $error("non-newline beat produced a line");

    // While the output is blocked, no stage moves.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(line_vld) && $stable(t_vld_reg) && $stable(mul_vld_reg)))
        else $error("pipeline moved during a stall");

    // A malformed line reports all-zero fields.
    a_malformed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_line_reg.status == ST_MALFORMED) |->
        (coord_x == '0 && coord_y == '0 && out_line_reg.distance == '0 &&
         out_line_reg.angle == '0))
        else $error("malformed line with nonzero fields");

    // The reported angle is always reduced below a full turn.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_line_reg.angle < ANGLE_W'(ANGLE_MOD)))
        else $error("angle not reduced modulo 360");
`endif

endmodule

@@ tb/apc_point_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// apc_point_checker: point predictor and comparator for the polar converter
// Watches the character, point and register ports, scans each accepted
// character with its own line parser, queues the point that every newline
// should produce and compares each point beat field by field.
// ============================================================================
module apc_point_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // s_tdata: rx_byte [7:0].
    input  logic [apc_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: point_x, point_y, distance, angle_deg, zero fill (low bit up).
    input  logic [apc_pkg::TDATA_W-1:0]    m_tdata,
    // m_tuser: status [1:0].
    input  logic [apc_pkg::STATUS_W-1:0]   m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [apc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [apc_pkg::CFG_W-1:0]      cfg_wdata,
    output int                             errors,
    output int                             pending,
    output int                             n_chars,
    output int                             n_points,
    output int                             n_far,
    output int                             n_bad
);
    import apc_pkg::*;

    // Bit positions of the point fields inside m_tdata.
    localparam int Y_LSB = POINT_W;
    localparam int D_LSB = 2 * POINT_W;
    localparam int A_LSB = D_LSB + DIST_W;

    // Rounding shift between the sine scale and the coordinate scale.
    localparam int DROP  = (SINE_FRAC_BITS > COORD_FRAC_BITS) ?
                           (SINE_FRAC_BITS - COORD_FRAC_BITS) : 0;
    localparam int RAISE = (SINE_FRAC_BITS > COORD_FRAC_BITS) ?
                           0 : (COORD_FRAC_BITS - SINE_FRAC_BITS);

    typedef struct {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic signed [DIST_W-1:0]  distance;
        logic [ANGLE_W-1:0]        angle;
        status_t                   status;
    } point_t;

    point_t pending_points[$];

    // Register copies.
    logic signed [CFG_W-1:0] cx;
    logic signed [CFG_W-1:0] cy;
    logic [CFG_W-1:0]        limit;

    // Line scanner state.
    bit    in_dist;
    scan_t scan;
    int    ang_res;
    bit    ang_neg;
    bit    ang_seen;
    int    dist_mag;
    bit    dist_neg;
    bit    dist_seen;
    bit    line_bad;

    int sine_tab [0:QUARTER];

    // One quarter-wave entry: Q30 Taylor series of sin(d degrees), rounded half up.
    function automatic int sine_entry(input int d);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        x    = (longint'(d) * PI_OVER_180_Q40 + 64'd512) >> 10;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return int'((acc + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS));
    endfunction

    initial begin
        for (int d = 0; d <= QUARTER; d++) begin
            sine_tab[d] = sine_entry(d);
        end
    end

    // Signed sine of a whole angle in 0..359 from the quarter-wave table.
    function automatic longint sine_deg(input int a);
        int q;
        int r;
        longint v;
        q = a / QUARTER;
        r = a % QUARTER;
        v = ((q % 2) == 1) ? sine_tab[QUARTER - r] : sine_tab[r];
        return ((q / 2) % 2 == 1) ? -v : v;
    endfunction

    // Center plus rounded distance times trig value, saturated to the point width.
    function automatic longint axis_coord(input int center, input longint dist_val,
                                          input longint trig);
        longint unsigned mag;
        longint term;
        longint total;
        mag = longint'(dist_val < 0 ? -dist_val : dist_val) *
              longint'(trig < 0 ? -trig : trig);
        if (DROP > 0) begin
            mag = (mag + ((64'd1 << DROP) >> 1)) >> DROP;
        end else begin
            mag = mag << RAISE;
        end
        term = longint'(mag);
        if ((dist_val < 0) != (trig < 0)) begin
            term = -term;
        end
        total = longint'(center) * (longint'(1) << COORD_FRAC_BITS) + term;
        if (total > PT_MAX) total = PT_MAX;
        if (total < PT_MIN) total = PT_MIN;
        return total;
    endfunction

    task automatic clear_line();
        in_dist   = 1'b0;
        scan      = SCAN_BEFORE;
        ang_res   = 0;
        ang_neg   = 1'b0;
        ang_seen  = 1'b0;
        dist_mag  = 0;
        dist_neg  = 1'b0;
        dist_seen = 1'b0;
        line_bad  = 1'b0;
    endtask

    // Advances the scanner by one character; a newline queues one point.
    task automatic scan_char(input logic [BYTE_W-1:0] c);
        bit     blank;
        bit     digit;
        int     d;
        int     a;
        int     m;
        longint dist_val;
        point_t p;
        blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
                (c == CH_VT) || (c == CH_FF);
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_NL) begin
            p.x        = '0;
            p.y        = '0;
            p.distance = '0;
            p.angle    = '0;
            p.status   = ST_MALFORMED;
            if (!line_bad && ang_seen && in_dist && dist_seen) begin
                a          = ang_neg ? (ANGLE_MOD - ang_res) % ANGLE_MOD : ang_res;
                dist_val   = dist_neg ? -longint'(dist_mag) : longint'(dist_mag);
                p.x        = POINT_W'(axis_coord(int'(cx), dist_val,
                                                 sine_deg((a + QUARTER) % ANGLE_MOD)));
                p.y        = POINT_W'(axis_coord(int'(cy), dist_val, sine_deg(a)));
                p.distance = DIST_W'(dist_val);
                p.angle    = ANGLE_W'(a);
                p.status   = (dist_val >= longint'(limit)) ? ST_OUT_OF_RANGE : ST_IN_RANGE;
            end
            pending_points.insert(pending_points.size(), p);
            clear_line();
        end else if (!in_dist && c == CH_COMMA) begin
            // The first comma switches to the distance field.
            if (!ang_seen) line_bad = 1'b1;
            in_dist = 1'b1;
            scan    = SCAN_BEFORE;
        end else if (scan == SCAN_BEFORE && blank) begin
            // Leading blanks are skipped.
        end else if (scan == SCAN_BEFORE && (c == CH_PLUS || c == CH_MINUS)) begin
            if (in_dist) begin
                dist_neg = (c == CH_MINUS);
            end else begin
                ang_neg = (c == CH_MINUS);
            end
            scan = SCAN_SIGN;
        end else if (scan != SCAN_DONE && digit) begin
            d = int'(c - CH_ZERO);
            if (in_dist) begin
                m         = dist_mag * 10 + d;
                dist_mag  = (m > MAG_MAX) ? MAG_MAX : m;
                dist_seen = 1'b1;
            end else begin
                ang_res  = (ang_res * 10 + d) % ANGLE_MOD;
                ang_seen = 1'b1;
            end
            scan = SCAN_DIGITS;
        end else begin
            scan = SCAN_DONE;
        end
    endtask

    // Compares one point beat with the oldest queued point.
    task automatic check_point(input logic [TDATA_W-1:0] data,
                               input logic [STATUS_W-1:0] user);
        point_t want;
        if (pending_points.size() == 0) begin
            $error("point beat with none expected: tdata %h status %0d", data, user);
            errors++;
            return;
        end
        want = pending_points[0];
        pending_points.delete(0);
        n_points++;
        if (want.status == ST_OUT_OF_RANGE) n_far++;
        if (want.status == ST_MALFORMED) n_bad++;
        if (data[0 +: POINT_W] !== want.x) begin
            $error("point_x: expected %0d, got %0d", want.x, $signed(data[0 +: POINT_W]));
            errors++;
        end
        if (data[Y_LSB +: POINT_W] !== want.y) begin
            $error("point_y: expected %0d, got %0d", want.y,
                   $signed(data[Y_LSB +: POINT_W]));
            errors++;
        end
        if (data[D_LSB +: DIST_W] !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance,
                   $signed(data[D_LSB +: DIST_W]));
            errors++;
        end
        if (data[A_LSB +: ANGLE_W] !== want.angle) begin
            $error("angle_deg: expected %0d, got %0d", want.angle, data[A_LSB +: ANGLE_W]);
            errors++;
        end
        if (data[PAYLOAD_W +: PAD_W] !== '0) begin
            $error("zero fill: expected 0, got %0d", data[PAYLOAD_W +: PAD_W]);
            errors++;
        end
        if (user !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, user);
            errors++;
        end
    endtask

    // Points leave before the character of this edge is scanned; register
    // writes happen only while nothing is in flight.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cx    = CENTER_X_RST;
            cy    = CENTER_Y_RST;
            limit = RANGE_LIM_RST;
            clear_line();
            pending_points.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_point(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                n_chars++;
                scan_char(s_tdata);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CENTER_X:    cx = cfg_wdata;
                    REG_CENTER_Y:    cy = cfg_wdata;
                    REG_RANGE_LIMIT: limit = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending = pending_points.size();
    end

endmodule

@@ tb/ascii_polar_to_cartesian_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ascii_polar_to_cartesian_core_tb: stimulus and verdict for the converter
// Sends directed and random sensor lines under several register settings,
// with random gaps and output stalls plus one long output hold-off; the
// checker beside the block predicts and compares every point.
// ============================================================================
module ascii_polar_to_cartesian_core_tb;
    import apc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = CFG_ADDR_W'(3);
    localparam int CHARS_PER_PHASE = 110;
    localparam int LONG_HOLD       = 150;
    localparam int DRAIN_CYCLES    = 12;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    int errors;
    int pending;
    int n_chars;
    int n_points;
    int n_far;
    int n_bad;

    // Set for the last phase: no gaps and no stalls.
    bit calm;
    // Asks the point sink for one long hold-off.
    bit hold_off;
    int cur_limit;
    int chars_in_phase;

    logic [BYTE_W-1:0] line_buf[$];
    logic [BYTE_W-1:0] blank_chars [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};

    ascii_polar_to_cartesian_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    apc_point_checker u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .n_chars   (n_chars),
        .n_points  (n_points),
        .n_far     (n_far),
        .n_bad     (n_bad)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("ascii_polar_to_cartesian_core verification failed");
        $finish;
    end

    // Point sink: random stall bursts, one long hold-off on request.
    initial begin : point_sink
        int n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 8);
                m_tready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offers one character after an optional gap and waits for its beat.
    task automatic send_char(input logic [BYTE_W-1:0] c);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = BYTE_W'($urandom);
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = c;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i]);
        end
    endtask

    // Drops valid and waits until every point is out and the pipe is empty.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge aclk);
    endtask

    // Writes all registers, plus the unused index, while the block is idle.
    task automatic set_config(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                              input logic [CFG_W-1:0] lim);
        drain();
        write_reg(REG_SPARE, CFG_W'($urandom));
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_RANGE_LIMIT, lim);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cfg_wdata = CFG_W'($urandom);
        cur_limit = lim;
    endtask

    // Adds one character at the end of the line being built.
    task automatic append_char(input logic [BYTE_W-1:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    // Appends one number field: blanks, sign, digits and trailing text at random.
    task automatic add_field(input longint unsigned value, input bit negative);
        string digits;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) append_char(blank_chars[$urandom_range(0, 4)]);
        end
        if (negative) begin
            append_char(CH_MINUS);
        end else if ($urandom_range(0, 4) == 0) begin
            append_char(CH_PLUS);
        end
        if ($urandom_range(0, 7) == 0) append_char(CH_ZERO);
        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++) begin
            append_char(digits[i]);
        end
        if ($urandom_range(0, 7) == 0) append_char(BYTE_W'($urandom_range(8'h3A, 8'h7E)));
    endtask

    // Mostly well-formed lines, some with one character removed, some noise.
    task automatic send_random_line();
        int kind;
        longint unsigned ang;
        longint unsigned dist_val;
        line_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind < 9) begin
            ang      = ($urandom_range(0, 4) == 0) ? longint'($urandom) :
                       $urandom_range(0, 800);
            dist_val = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 9999999) :
                       $urandom_range(0, (cur_limit > 30000) ? 70000 : 2 * cur_limit + 20);
            add_field(ang, $urandom_range(0, 4) == 0);
            append_char(CH_COMMA);
            add_field(dist_val, $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                append_char(CH_COMMA);
                append_char(BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
            end
            if (kind == 8) line_buf.delete($urandom_range(0, line_buf.size() - 1));
        end else begin
            repeat ($urandom_range(1, 12)) append_char(BYTE_W'($urandom_range(0, 255)));
        end
        append_char(CH_NL);
        foreach (line_buf[i]) send_char(line_buf[i]);
        chars_in_phase += line_buf.size();
    endtask

    task automatic run_random(input int chars);
        chars_in_phase = 0;
        while (chars_in_phase < chars) send_random_line();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        cur_limit = RANGE_LIM_RST;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: plain points, limit edges, distance saturation,
        // signs, blanks, angle wrap, each malformed shape, trailing text
        // and bytes with the top bit set.
        send_text("0,100\n");
        send_text("90,449\n");
        send_text("180,450\n");
        send_text("270,99999\n");
        send_text("-90,-5\n");
        send_text(" \t+45,\015\013\014+12\n");
        send_text("3600000,7\n");
        send_text(",5\n");
        send_text("5\n");
        send_text("5,\n");
        send_text("-,3\n");
        send_text("1,+\n");
        send_text("12x,34abc,56\n");
        send_text("\n");
        send_text("359\377,8\200\n");
        send_text("1 2 , 3 4\n");

        // Center at the extremes with a zero limit: every point is beyond it
        // unless the distance is negative.
        set_config(16'h8000, 16'h7FFF, 16'h0000);
        send_text("0,65535\n");
        send_text("180,65535\n");
        send_text("-0,0\n");
        send_text("45,-65535\n");

        // Random lines, with the output held off long enough to back up the pipe.
        set_config(CENTER_X_RST, CENTER_Y_RST, RANGE_LIM_RST);
        repeat (3) send_random_line();
        hold_off = 1'b1;
        run_random(CHARS_PER_PHASE);

        set_config(16'h8000, 16'h7FFF, 16'h0000);
        run_random(CHARS_PER_PHASE);

        set_config(16'h7FFF, 16'h8000, 16'hFFFF);
        run_random(CHARS_PER_PHASE);

        set_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 2000)));
        run_random(CHARS_PER_PHASE);

        // Last phase at full rate on both sides.
        set_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        calm = 1'b1;
        run_random(CHARS_PER_PHASE);

        drain();
        $display("Sent %0d characters under several register settings; checked %0d points.",
                 n_chars, n_points);
        $display("Of those points %0d were beyond the range limit and %0d malformed.",
                 n_far, n_bad);
        if (errors == 0) begin
            $display("ascii_polar_to_cartesian_core verification clean");
        end else begin
            $display("ascii_polar_to_cartesian_core verification failed");
        end
        $finish;
    end

endmodule
